### rtl/core/aavr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aavr_pkg
// Shared codes, widths and the CORDIC arctangent table of the vertex rotator.
// ----------------------------------------------------------------------------
package aavr_pkg;

	localparam int AXIS_W  = 16;
	localparam int ANGLE_W = 16;
	localparam int CFG_W   = 16;
	localparam int Q_W     = 34;
	localparam int CORDIC_STEPS = 30;
	localparam logic signed [Q_W-1:0] CORDIC_START = 34'sd652032874;

	typedef enum logic [2:0] {
		REG_AXIS_X = 3'd0,
		REG_AXIS_Y = 3'd1,
		REG_AXIS_Z = 3'd2,
		REG_ANGLE  = 3'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		Q_A = 2'd0,
		Q_B = 2'd1,
		Q_C = 2'd2,
		Q_D = 2'd3
	} qsel_t;

	function automatic logic signed [Q_W-1:0] cordic_atan(input logic [4:0] idx);
		logic signed [Q_W-1:0] r;
		begin
			unique case (idx)
				5'd0:  r = 34'sd536870912;
				5'd1:  r = 34'sd316933406;
				5'd2:  r = 34'sd167458907;
				5'd3:  r = 34'sd85004756;
				5'd4:  r = 34'sd42667331;
				5'd5:  r = 34'sd21354465;
				5'd6:  r = 34'sd10679838;
				5'd7:  r = 34'sd5340245;
				5'd8:  r = 34'sd2670163;
				5'd9:  r = 34'sd1335087;
				5'd10: r = 34'sd667544;
				5'd11: r = 34'sd333772;
				5'd12: r = 34'sd166886;
				5'd13: r = 34'sd83443;
				5'd14: r = 34'sd41722;
				5'd15: r = 34'sd20861;
				5'd16: r = 34'sd10430;
				5'd17: r = 34'sd5215;
				5'd18: r = 34'sd2608;
				5'd19: r = 34'sd1304;
				5'd20: r = 34'sd652;
				5'd21: r = 34'sd326;
				5'd22: r = 34'sd163;
				5'd23: r = 34'sd81;
				5'd24: r = 34'sd41;
				5'd25: r = 34'sd20;
				5'd26: r = 34'sd10;
				5'd27: r = 34'sd5;
				5'd28: r = 34'sd3;
				5'd29: r = 34'sd1;
				default: r = 34'sd0;
			endcase
			return r;
		end
	endfunction

endpackage
`default_nettype wire

### rtl/core/aavr_matrix_gen.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aavr_matrix_gen
// Holds the configuration registers and rebuilds the rotation matrix after
// each write: axis norm by bit-serial square root, unit axis by restoring
// division, half-angle cos/sin by CORDIC, quaternion, then nine coefficients.
// ----------------------------------------------------------------------------
module aavr_matrix_gen #(
	parameter int COEF_FRAC_BITS = 16,
	parameter int CW = COEF_FRAC_BITS + 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [2:0] cfg_idx,
	input  wire logic [aavr_pkg::CFG_W-1:0] cfg_wdata,
	output logic busy,
	output logic signed [CW-1:0] mtx [9]
);

	localparam int QW = aavr_pkg::Q_W;
	localparam int PW = 2 * QW;
	localparam int AW = PW + 2;
	localparam logic signed [AW-1:0] ONE_Q60 = AW'(1) <<< 60;
	localparam logic signed [AW-1:0] ROUND_K = AW'(1) <<< (59 - COEF_FRAC_BITS);
	localparam logic signed [AW-1:0] C_MAX = (AW'(1) <<< (COEF_FRAC_BITS + 3)) - AW'(1);
	localparam logic signed [AW-1:0] C_MIN = -(AW'(1) <<< (COEF_FRAC_BITS + 3));
	localparam logic signed [CW-1:0] C_ONE = CW'(1) <<< COEF_FRAC_BITS;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CHECK, ST_SQ, ST_ROOT, ST_DIV, ST_CORDIC, ST_QUAT, ST_COEF
	} state_t;

	state_t st_q;
	logic signed [aavr_pkg::AXIS_W-1:0] ax_q, ay_q, az_q;
	logic [aavr_pkg::ANGLE_W-1:0] ang_q;
	logic [3:0] k_q;
	logic [4:0] cnt_q;
	logic [1:0] ph_q;
	logic [31:0] sq_q;
	logic [63:0] n_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [30:0] quo_q;
	logic signed [31:0] u_q [3];
	logic signed [QW-1:0] cx_q, cy_q, cz_q, sy_q;
	logic flip_q;
	logic signed [QW-1:0] qa_q, qb_q, qc_q, qd_q;
	logic signed [PW-1:0] prod_q;
	logic signed [AW-1:0] acc_q;

	function automatic logic signed [15:0] axis_at(input logic [1:0] k,
		input logic signed [15:0] x, input logic signed [15:0] y,
		input logic signed [15:0] z);
		begin
			case (k)
				2'd0: return x;
				2'd1: return y;
				default: return z;
			endcase
		end
	endfunction

	function automatic logic [15:0] mag16(input logic signed [15:0] a);
		begin
			return a[15] ? 16'(-a) : 16'(a);
		end
	endfunction

	function automatic logic signed [QW-1:0] qval(input aavr_pkg::qsel_t s,
		input logic signed [QW-1:0] a, input logic signed [QW-1:0] b,
		input logic signed [QW-1:0] c, input logic signed [QW-1:0] d);
		begin
			unique case (s)
				aavr_pkg::Q_A: return a;
				aavr_pkg::Q_B: return b;
				aavr_pkg::Q_C: return c;
				aavr_pkg::Q_D: return d;
				default: return a;
			endcase
		end
	endfunction

	logic cfg_hit;
	logic signed [15:0] a_sel, a_nxt;
	logic signed [31:0] a_ext;
	logic [31:0] sq_next;
	logic [35:0] rem_t, trial;
	logic root_ge;
	logic [33:0] rem2;
	logic div_ge;
	logic [30:0] quo_next;
	logic signed [31:0] u_val;
	logic signed [QW-1:0] xs, ys, atan, cx_n, cy_n, cz_n, z0;
	logic signed [65:0] qprod;
	aavr_pkg::qsel_t s1l, s1r, s2l, s2r;
	logic n1, n2, base_en;
	logic signed [QW-1:0] opl, opr;
	logic signed [PW-1:0] mprod;
	logic signed [AW-1:0] term, acc_n, vsum, c_full;
	logic signed [CW-1:0] coef;

	assign cfg_hit = cfg_we && (cfg_idx <= aavr_pkg::REG_ANGLE);
	assign busy = (st_q != ST_IDLE);

	always_comb begin
		a_sel = axis_at(k_q[1:0], ax_q, ay_q, az_q);
		a_nxt = axis_at(2'(k_q[1:0] + 2'd1), ax_q, ay_q, az_q);
		a_ext = 32'(a_sel);
		sq_next = sq_q + 32'(a_ext * a_ext);

		rem_t = {rem_q, n_q[63:62]};
		trial = {2'b00, root_q, 2'b01};
		root_ge = (rem_t >= trial);

		rem2 = {rem_q[32:0], 1'b0};
		div_ge = (rem2 >= {2'b00, root_q});
		quo_next = {quo_q[29:0], div_ge};
		u_val = a_sel[15] ? -$signed(32'(quo_next)) : $signed(32'(quo_next));

		xs = cx_q >>> cnt_q;
		ys = cy_q >>> cnt_q;
		atan = aavr_pkg::cordic_atan(cnt_q);
		cx_n = cz_q[QW-1] ? cx_q + ys : cx_q - ys;
		cy_n = cz_q[QW-1] ? cy_q - xs : cy_q + xs;
		cz_n = cz_q[QW-1] ? cz_q + atan : cz_q - atan;
		z0 = $signed({3'b000, ang_q, 15'd0})
			- (ang_q[15] ? 34'sd2147483648 : 34'sd0);

		qprod = 66'(u_q[k_q[1:0]]) * 66'(sy_q);

		s1l = aavr_pkg::Q_A; s1r = aavr_pkg::Q_A;
		s2l = aavr_pkg::Q_A; s2r = aavr_pkg::Q_A;
		n1 = 1'b0; n2 = 1'b0; base_en = 1'b0;
		case (k_q)
			4'd0: begin
				s1l = aavr_pkg::Q_C; s1r = aavr_pkg::Q_C; n1 = 1'b1;
				s2l = aavr_pkg::Q_D; s2r = aavr_pkg::Q_D; n2 = 1'b1; base_en = 1'b1;
			end
			4'd1: begin
				s1l = aavr_pkg::Q_B; s1r = aavr_pkg::Q_C;
				s2l = aavr_pkg::Q_A; s2r = aavr_pkg::Q_D; n2 = 1'b1;
			end
			4'd2: begin
				s1l = aavr_pkg::Q_A; s1r = aavr_pkg::Q_C;
				s2l = aavr_pkg::Q_B; s2r = aavr_pkg::Q_D;
			end
			4'd3: begin
				s1l = aavr_pkg::Q_B; s1r = aavr_pkg::Q_C;
				s2l = aavr_pkg::Q_A; s2r = aavr_pkg::Q_D;
			end
			4'd4: begin
				s1l = aavr_pkg::Q_B; s1r = aavr_pkg::Q_B; n1 = 1'b1;
				s2l = aavr_pkg::Q_D; s2r = aavr_pkg::Q_D; n2 = 1'b1; base_en = 1'b1;
			end
			4'd5: begin
				s1l = aavr_pkg::Q_C; s1r = aavr_pkg::Q_D;
				s2l = aavr_pkg::Q_A; s2r = aavr_pkg::Q_B; n2 = 1'b1;
			end
			4'd6: begin
				s1l = aavr_pkg::Q_B; s1r = aavr_pkg::Q_D;
				s2l = aavr_pkg::Q_A; s2r = aavr_pkg::Q_C; n2 = 1'b1;
			end
			4'd7: begin
				s1l = aavr_pkg::Q_A; s1r = aavr_pkg::Q_B;
				s2l = aavr_pkg::Q_C; s2r = aavr_pkg::Q_D;
			end
			default: begin
				s1l = aavr_pkg::Q_B; s1r = aavr_pkg::Q_B; n1 = 1'b1;
				s2l = aavr_pkg::Q_C; s2r = aavr_pkg::Q_C; n2 = 1'b1; base_en = 1'b1;
			end
		endcase
		opl = qval((ph_q == 2'd0) ? s1l : s2l, qa_q, qb_q, qc_q, qd_q);
		opr = qval((ph_q == 2'd0) ? s1r : s2r, qa_q, qb_q, qc_q, qd_q);
		mprod = PW'(opl) * PW'(opr);

		term = AW'(prod_q) <<< 1;
		acc_n = (base_en ? ONE_Q60 : AW'(0)) + (n1 ? -term : term);
		vsum = acc_q + (n2 ? -term : term);
		c_full = (vsum + ROUND_K) >>> (60 - COEF_FRAC_BITS);
		if (c_full > C_MAX)
			coef = C_MAX[CW-1:0];
		else if (c_full < C_MIN)
			coef = C_MIN[CW-1:0];
		else
			coef = c_full[CW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ax_q <= '0; ay_q <= '0; az_q <= '0; ang_q <= '0;
			k_q <= '0; cnt_q <= '0; ph_q <= '0;
			for (int e = 0; e < 9; e++)
				mtx[e] <= (e % 4 == 0) ? C_ONE : '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					aavr_pkg::REG_AXIS_X: ax_q <= cfg_wdata;
					aavr_pkg::REG_AXIS_Y: ay_q <= cfg_wdata;
					aavr_pkg::REG_AXIS_Z: az_q <= cfg_wdata;
					aavr_pkg::REG_ANGLE:  ang_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cfg_hit) begin
				st_q <= ST_CHECK;
			end else begin
				unique case (st_q)
					ST_IDLE: ;
					ST_CHECK: begin
						for (int e = 0; e < 9; e++)
							mtx[e] <= (e % 4 == 0) ? C_ONE : '0;
						sq_q <= '0;
						k_q <= '0;
						if ((ax_q == 0 && ay_q == 0 && az_q == 0) || ang_q == 0)
							st_q <= ST_IDLE;
						else
							st_q <= ST_SQ;
					end
					ST_SQ: begin
						if (k_q == 4'd2) begin
							n_q <= {sq_next, 32'd0};
							rem_q <= '0;
							root_q <= '0;
							cnt_q <= 5'd31;
							k_q <= '0;
							st_q <= ST_ROOT;
						end else begin
							sq_q <= sq_next;
							k_q <= k_q + 4'd1;
						end
					end
					ST_ROOT: begin
						n_q <= {n_q[61:0], 2'b00};
						root_q <= {root_q[30:0], root_ge};
						if (cnt_q == 5'd0) begin
							rem_q <= {3'b000, mag16(a_sel), 15'd0};
							quo_q <= '0;
							cnt_q <= 5'd30;
							st_q <= ST_DIV;
						end else begin
							rem_q <= root_ge ? 34'(rem_t - trial) : rem_t[33:0];
							cnt_q <= cnt_q - 5'd1;
						end
					end
					ST_DIV: begin
						if (cnt_q == 5'd0) begin
							u_q[k_q[1:0]] <= u_val;
							quo_q <= '0;
							rem_q <= {3'b000, mag16(a_nxt), 15'd0};
							if (k_q == 4'd2) begin
								cx_q <= aavr_pkg::CORDIC_START;
								cy_q <= '0;
								cz_q <= z0;
								flip_q <= ang_q[15];
								cnt_q <= '0;
								st_q <= ST_CORDIC;
							end else begin
								cnt_q <= 5'd30;
								k_q <= k_q + 4'd1;
							end
						end else begin
							rem_q <= div_ge ? 34'(rem2 - {2'b00, root_q}) : rem2;
							quo_q <= quo_next;
							cnt_q <= cnt_q - 5'd1;
						end
					end
					ST_CORDIC: begin
						cx_q <= cx_n;
						cy_q <= cy_n;
						cz_q <= cz_n;
						cnt_q <= cnt_q + 5'd1;
						if (cnt_q == 5'(aavr_pkg::CORDIC_STEPS - 1)) begin
							qa_q <= flip_q ? -cx_n : cx_n;
							sy_q <= flip_q ? -cy_n : cy_n;
							k_q <= '0;
							st_q <= ST_QUAT;
						end
					end
					ST_QUAT: begin
						case (k_q)
							4'd0: qb_q <= qprod[30 +: QW];
							4'd1: qc_q <= qprod[30 +: QW];
							default: qd_q <= qprod[30 +: QW];
						endcase
						if (k_q == 4'd2) begin
							k_q <= '0;
							ph_q <= '0;
							st_q <= ST_COEF;
						end else begin
							k_q <= k_q + 4'd1;
						end
					end
					ST_COEF: begin
						case (ph_q)
							2'd0: begin
								prod_q <= mprod;
								ph_q <= 2'd1;
							end
							2'd1: begin
								acc_q <= acc_n;
								prod_q <= mprod;
								ph_q <= 2'd2;
							end
							default: begin
								mtx[k_q] <= coef;
								ph_q <= 2'd0;
								if (k_q == 4'd8)
									st_q <= ST_IDLE;
								else
									k_q <= k_q + 4'd1;
							end
						endcase
					end
					default: st_q <= ST_IDLE;
				endcase
			end
		end
	end

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV) |-> (rem_q < {2'b00, root_q}))
		else $error("division remainder not below divisor");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CHECK) |-> $past(cfg_hit))
		else $error("matrix rebuild started without a register write");

	a_cordic_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CORDIC) |-> (cnt_q < 5'(aavr_pkg::CORDIC_STEPS)))
		else $error("CORDIC step count out of range");

	a_coef_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_COEF) |-> (k_q <= 4'd8))
		else $error("coefficient index out of range");

endmodule
`default_nettype wire

### rtl/core/axis_angle_vertex_rotator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// axis_angle_vertex_rotator_core
// Rotates a stream of Q16.16 vertices by a 3x3 matrix built from an axis and
// an angle; rounds and saturates each result coordinate.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  s_*      in         tdata: vertex_x, vertex_y, vertex_z
//  m_*      out        tdata: rotated_x, rotated_y, rotated_z
//  cfg_*    in         cfg_idx 0..3: axis_x, axis_y, axis_z, rotation_angle
//
//  One item per cycle while the output is not stalled and no config write
//  or rebuild is under way; 5 register stages, so items overlap in flight.
//  Stages: input reg, 18 partial products, row sums, round/shift, saturate.
//  Each write to cfg_idx 0..3 rebuilds the matrix (32-step square root,
//  three 31-step divisions, 30 CORDIC steps, nine coefficients); s_tready
//  is low meanwhile and during the write itself.
//  Reset loads the identity matrix and empties the pipeline.
//  Each stage holds while its successor is full and stalled.
// ----------------------------------------------------------------------------
module axis_angle_vertex_rotator_core #(
	parameter int COEF_FRAC_BITS = 16,
	parameter int COORD_WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	// vertex_x, vertex_y, vertex_z
	input  wire logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	output logic m_tvalid,
	input  wire logic m_tready,
	// rotated_x, rotated_y, rotated_z
	output logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
	input  wire logic cfg_we,
	input  wire logic [2:0] cfg_idx,
	input  wire logic [aavr_pkg::CFG_W-1:0] cfg_wdata
);

	localparam int W    = COORD_WIDTH;
	localparam int CW   = COEF_FRAC_BITS + 4;
	localparam int LO_W = W / 2;
	localparam int HI_W = W - LO_W;
	localparam int PH_W = CW + HI_W;
	localparam int PL_W = CW + LO_W + 1;
	localparam int H_W  = PH_W + 2;
	localparam int L_W  = PL_W + 2;
	localparam int SW   = CW + W + 4;
	localparam logic signed [SW-1:0] RND  = SW'(1) <<< (COEF_FRAC_BITS - 1);
	localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< (W - 1)) - SW'(1);
	localparam logic signed [SW-1:0] MINV = -(SW'(1) <<< (W - 1));

	logic gen_busy;
	logic signed [CW-1:0] mtx [9];

	aavr_matrix_gen #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS),
		.CW(CW)
	) u_gen (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.busy(gen_busy),
		.mtx(mtx)
	);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic in_acc;
	logic signed [HI_W-1:0] vh_s1 [3];
	logic [LO_W-1:0] vl_s1 [3];
	logic signed [PH_W-1:0] ph_s2 [3][3];
	logic signed [PL_W-1:0] pl_s2 [3][3];
	logic signed [H_W-1:0] h_s3 [3];
	logic signed [L_W-1:0] l_s3 [3];
	logic signed [SW-1:0] t_s4 [3];
	logic [W-1:0] res_s5 [3];
	logic signed [SW-1:0] rsum [3];

	assign rdy5 = !v_s5 || m_tready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign s_tready = rdy1 && !gen_busy && !cfg_we;
	assign in_acc = s_tvalid && s_tready;
	assign m_tvalid = v_s5;

	always_comb begin
		m_tdata = '0;
		for (int i = 0; i < 3; i++) begin
			m_tdata[i*W +: W] = res_s5[i];
			rsum[i] = (SW'(h_s3[i]) <<< LO_W) + SW'(l_s3[i]) + RND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_acc;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_acc) begin
			for (int j = 0; j < 3; j++) begin
				vh_s1[j] <= s_tdata[j*W + LO_W +: HI_W];
				vl_s1[j] <= s_tdata[j*W +: LO_W];
			end
		end
		if (rdy2 && v_s1) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					ph_s2[i][j] <= PH_W'(mtx[3*i+j]) * PH_W'(vh_s1[j]);
					pl_s2[i][j] <= PL_W'(mtx[3*i+j]) * PL_W'($signed({1'b0, vl_s1[j]}));
				end
		end
		if (rdy3 && v_s2) begin
			for (int i = 0; i < 3; i++) begin
				h_s3[i] <= H_W'(ph_s2[i][0]) + H_W'(ph_s2[i][1]) + H_W'(ph_s2[i][2]);
				l_s3[i] <= L_W'(pl_s2[i][0]) + L_W'(pl_s2[i][1]) + L_W'(pl_s2[i][2]);
			end
		end
		if (rdy4 && v_s3) begin
			for (int i = 0; i < 3; i++)
				t_s4[i] <= rsum[i] >>> COEF_FRAC_BITS;
		end
		if (rdy5 && v_s4) begin
			for (int i = 0; i < 3; i++) begin
				if (t_s4[i] > MAXV)
					res_s5[i] <= MAXV[W-1:0];
				else if (t_s4[i] < MINV)
					res_s5[i] <= MINV[W-1:0];
				else
					res_s5[i] <= t_s4[i][W-1:0];
			end
		end
	end

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !rdy2) |=> v_s1)
		else $error("stage 1 item dropped under stall");

	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !rdy5) |=> v_s4)
		else $error("stage 4 item dropped under stall");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !v_s4) |=> !m_tvalid)
		else $error("output item repeated after it was taken");

endmodule
`default_nettype wire
